// File: hdl/mesi_pkg.sv
// Package for the MESI snooping cache controller: item types, MESI codes,
// mode and bus request codes. No dependencies.
`default_nettype none
package mesi_pkg;

  localparam int AddrW = 32;
  localparam int TagW  = 30;

  typedef enum logic [2:0] {
    MODE_READ   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_TOUCH  = 3'd2,
    MODE_BUSRD  = 3'd3,
    MODE_BUSRDX = 3'd4,
    MODE_BUSUPG = 3'd5,
    MODE_PROBE  = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;

  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;

  localparam logic [1:0] BUS_NONE = 2'd0;
  localparam logic [1:0] BUS_RD   = 2'd1;
  localparam logic [1:0] BUS_RDX  = 2'd2;
  localparam logic [1:0] BUS_UPG  = 2'd3;

  localparam logic [1:0] CFG_BLOCK = 2'd0;
  localparam logic [1:0] CFG_SETS  = 2'd1;
  localparam logic [1:0] CFG_WAYS  = 2'd2;

  typedef struct packed {
    logic [2:0]       mode;
    logic [AddrW-1:0] address;
    logic             shared_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       bus_request;
    logic             evicted;
    logic [AddrW-1:0] evict_address;
    logic             writeback;
    logic             flush;
    logic             hit;
    logic             found;
    logic             inclusion_error;
    logic             cache_to_cache;
    logic             intervention;
    logic             invalidation;
    logic [1:0]       state_after;
  } out_item_t;

endpackage
`default_nettype wire

// File: hdl/mesi_front.sv
// Front end: accepts items and decodes tag, set and way count from the
// configuration into a queued request. Depends on mesi_pkg.
`default_nettype none
module mesi_front
  import mesi_pkg::*;
#(
  parameter int SetW = 8,
  parameter int WayW = 4,
  parameter int MaxWays = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire in_item_t        in_data,
  input  wire logic [2:0]      blk_log2,
  input  wire logic [3:0]      set_log2,
  input  wire logic [3:0]      ways_cfg,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output logic [2:0]           q_mode,
  output logic [TagW-1:0]      q_tag,
  output logic [SetW-1:0]      q_set,
  output logic [2:0]           q_bb,
  output logic [WayW:0]        q_ways,
  output logic                 q_shared
);
  localparam int Depth = 2;
  typedef struct packed {
    logic [2:0]      mode;
    logic [TagW-1:0] tag;
    logic [SetW-1:0] set;
    logic [2:0]      bb;
    logic [WayW:0]   ways;
    logic            shared;
  } req_t;

  req_t            q_r [Depth];
  logic [0:0]      wp_r, rp_r;
  logic [1:0]      cnt_r;
  req_t            nreq;
  logic [2:0]      bb;
  logic [AddrW-1:0] tag_full;
  logic [15:0]     setmask;
  logic            push;

  always_comb begin
    bb = (blk_log2 < 3'd2) ? 3'd2 : blk_log2;
    tag_full = in_data.address >> bb;
    setmask = (16'd1 << set_log2) - 16'd1;
    nreq.mode = in_data.mode;
    nreq.tag = tag_full[TagW-1:0];
    nreq.set = tag_full[SetW-1:0] & setmask[SetW-1:0];
    nreq.bb = bb;
    if (ways_cfg == 4'd0) nreq.ways = (WayW+1)'(1);
    else if (32'(ways_cfg) > MaxWays) nreq.ways = (WayW+1)'(MaxWays);
    else nreq.ways = (WayW+1)'(ways_cfg);
    nreq.shared = in_data.shared_line;
  end

  assign in_ready = (cnt_r != 2'(Depth));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_mode = q_r[rp_r].mode;
  assign q_tag = q_r[rp_r].tag;
  assign q_set = q_r[rp_r].set;
  assign q_bb = q_r[rp_r].bb;
  assign q_ways = q_r[rp_r].ways;
  assign q_shared = q_r[rp_r].shared;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= nreq;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

// File: hdl/mesi_back.sv
// Back end: reads the set's ways, looks up, picks a victim and writes the
// line, then holds the result item. Depends on mesi_pkg.
`default_nettype none
module mesi_back
  import mesi_pkg::*;
#(
  parameter int SetW = 8,
  parameter int WayW = 4,
  parameter int MaxWays = 8,
  parameter int NSets = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire logic [2:0]      q_mode,
  input  wire logic [TagW-1:0] q_tag,
  input  wire logic [SetW-1:0] q_set,
  input  wire logic [2:0]      q_bb,
  input  wire logic [WayW:0]   q_ways,
  input  wire logic            q_shared,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output out_item_t            out_data
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_CLR  = 3'b100
  } state_t;

  localparam int IdxW = (MaxWays > 1) ? $clog2(MaxWays) : 1;

  logic [TagW-1:0] tag_mem   [NSets][MaxWays];
  logic [1:0]      st_mem    [NSets][MaxWays];
  logic [31:0]     stamp_mem [NSets][MaxWays];
  logic [TagW-1:0] rtag   [MaxWays];
  logic [1:0]      rst_v  [MaxWays];
  logic [31:0]     rstamp [MaxWays];

  state_t          state_r, state_nxt;
  logic [SetW-1:0] clr_r;
  logic [31:0]     astamp_r;
  logic            oval_r;
  out_item_t       odata_r;

  logic            hitv;
  logic [IdxW-1:0] hitw, invw, oldw, vic;
  logic            anyinv;
  logic [31:0]     best;
  logic            do_wr, stamp_wr;
  logic [IdxW-1:0] wway;
  logic [1:0]      wst;
  logic [31:0]     nstamp;
  out_item_t       res;
  logic            counts;

  always_ff @(posedge clk) begin
    for (int w = 0; w < MaxWays; w++) begin
      rtag[w] <= tag_mem[q_set][w];
      rst_v[w] <= st_mem[q_set][w];
      rstamp[w] <= stamp_mem[q_set][w];
    end
  end

  always_comb begin
    hitv = 1'b0; hitw = '0; anyinv = 1'b0; invw = '0;
    oldw = '0; best = 32'hFFFF_FFFF;
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if ((WayW+1)'(w) < q_ways) begin
        if (rst_v[w] != ST_I && rtag[w] == q_tag) begin
          hitv = 1'b1; hitw = IdxW'(w);
        end
        if (rst_v[w] == ST_I) begin
          anyinv = 1'b1; invw = IdxW'(w);
        end
      end
    end
    for (int w = 0; w < MaxWays; w++) begin
      if ((WayW+1)'(w) < q_ways && rstamp[w] <= best) begin
        best = rstamp[w]; oldw = IdxW'(w);
      end
    end
    vic = anyinv ? invw : oldw;
    counts = (q_mode != MODE_PROBE) && (q_mode != MODE_NONE);
    nstamp = astamp_r + 32'(counts);
    res = '0;
    do_wr = 1'b0; stamp_wr = 1'b0; wway = hitw; wst = rst_v[hitw];
    unique case (q_mode)
      MODE_PROBE: begin
        res.hit = hitv; res.found = hitv;
        res.state_after = hitv ? rst_v[hitw] : ST_I;
      end
      MODE_TOUCH: begin
        if (!hitv) res.inclusion_error = 1'b1;
        else begin
          stamp_wr = 1'b1; res.hit = 1'b1; res.state_after = rst_v[hitw];
        end
      end
      MODE_READ, MODE_WRITE: begin
        if (!hitv) begin
          wway = vic; do_wr = 1'b1; stamp_wr = 1'b1;
          if (!anyinv) begin
            res.evicted = 1'b1;
            res.evict_address = AddrW'({2'b00, rtag[vic]} << q_bb);
            res.writeback = (rst_v[vic] == ST_M);
          end
          res.cache_to_cache = q_shared;
          if (q_mode == MODE_WRITE) begin
            wst = ST_M; res.bus_request = BUS_RDX;
          end else begin
            wst = q_shared ? ST_S : ST_E; res.bus_request = BUS_RD;
          end
          res.state_after = wst;
        end else begin
          stamp_wr = 1'b1; res.hit = 1'b1;
          if (q_mode == MODE_WRITE) begin
            if (rst_v[hitw] == ST_S) res.bus_request = BUS_UPG;
            wst = ST_M; do_wr = 1'b1;
          end
          res.state_after = wst;
        end
      end
      MODE_BUSRD, MODE_BUSRDX, MODE_BUSUPG: begin
        if (hitv) begin
          res.hit = 1'b1;
          if (q_mode == MODE_BUSRD) begin
            if (rst_v[hitw] == ST_M || rst_v[hitw] == ST_E) begin
              res.intervention = 1'b1; res.flush = (rst_v[hitw] == ST_M);
              wst = ST_S; do_wr = 1'b1;
            end
          end else if (q_mode == MODE_BUSRDX || rst_v[hitw] == ST_S) begin
            res.flush = (rst_v[hitw] == ST_M); res.invalidation = 1'b1;
            wst = ST_I; do_wr = 1'b1;
          end
          res.state_after = wst;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    unique case (state_r)
      S_CLR: if (clr_r == SetW'(NSets - 1)) state_nxt = S_IDLE;
      S_IDLE: if (q_valid) state_nxt = S_EXEC;
      S_EXEC: if (!oval_r || out_ready) begin
        q_pop = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      for (int w = 0; w < MaxWays; w++) begin
        st_mem[clr_r][w] <= ST_I;
        stamp_mem[clr_r][w] <= '0;
      end
    end else if (q_pop) begin
      if (do_wr) st_mem[q_set][wway] <= wst;
      if (do_wr && !hitv) tag_mem[q_set][wway] <= q_tag;
      if (stamp_wr) stamp_mem[q_set][wway] <= nstamp;
    end
    if (q_pop) odata_r <= res;
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      astamp_r <= '0;
      oval_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (q_pop) astamp_r <= nstamp;
      if (q_pop) oval_r <= 1'b1;
      else if (out_ready) oval_r <= 1'b0;
    end
  end

  assign out_valid = oval_r;
  assign out_data = odata_r;
endmodule
`default_nettype wire

// File: hdl/mesi_snooping_cache_controller.sv
// MESI snooping cache controller top level: front end, request queue and
// back end. After reset a clearing pass over all MAX_SETS sets (256 by
// default) runs before the first item is carried out. The back end reads
// each item's set (tags, states, stamps) in S_IDLE, then in S_EXEC looks
// up, chooses a victim and writes the line; a two-entry queue and an
// output register let the input and output stall apart.
`default_nettype none
module mesi_snooping_cache_controller
  import mesi_pkg::*;
#(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata
);
  localparam int SetW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WayW = $clog2(MAX_WAYS + 1);

  logic [2:0]      blk_r;
  logic [3:0]      sets_r, ways_r;
  logic            q_valid, q_pop, q_shared;
  logic [2:0]      q_mode, q_bb;
  logic [TagW-1:0] q_tag;
  logic [SetW-1:0] q_set;
  logic [WayW:0]   q_ways;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r <= 3'd6;
      sets_r <= 4'd8;
      ways_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK: blk_r <= cfg_wdata[2:0];
        CFG_SETS:  sets_r <= cfg_wdata;
        CFG_WAYS:  ways_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mesi_front #(.SetW(SetW), .WayW(WayW), .MaxWays(MAX_WAYS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .blk_log2(blk_r), .set_log2(sets_r), .ways_cfg(ways_r),
    .q_valid, .q_pop, .q_mode, .q_tag, .q_set, .q_bb, .q_ways, .q_shared
  );

  mesi_back #(.SetW(SetW), .WayW(WayW), .MaxWays(MAX_WAYS), .NSets(MAX_SETS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_mode, .q_tag, .q_set, .q_bb,
    .q_ways, .q_shared, .out_valid, .out_ready, .out_data
  );

  a_found_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.hit) else $error("found without hit");
  a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.writeback |-> out_data.evicted) else $error("writeback without evict");
  a_inv_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalidation |-> out_data.state_after == ST_I)
    else $error("invalidated line not invalid");
endmodule
`default_nettype wire
